@@ src/quaternion_to_euler_unit_assert.svh @@
// Assertion macros for the quaternion to Euler unit checker
`ifndef QUATERNION_TO_EULER_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_UNIT_ASSERT_SVH

// property that must hold after reset
`define Q2E_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, CORDIC angle table and stage types for the quaternion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package q2e_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 30;
	localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	// datapath width: operands up to about 2^32, growth from CORDIC gain
	localparam int DW  = 36;
	localparam int AW  = 33;
	localparam int SQW = 31;
	localparam logic [30:0] THRESH_RST = 31'd1073731087;
	localparam logic signed [DW-1:0] ONE_Q30 = DW'(64'sd1073741824);

	typedef logic signed [DW-1:0] dval_t;
	typedef logic signed [AW-1:0] ang_t;

	typedef struct packed {
		dval_t x;
		dval_t y;
		ang_t  acc;
		logic  zero;
	} vec_t;

	typedef struct packed {
		vec_t p;
		vec_t yw;
		vec_t r;
		logic lock;
	} lane_t;

	function automatic ang_t atan_entry(input int i);
		ang_t t;
		unique case (i)
			0: t = AW'(32'h20000000);  1: t = AW'(32'h12E4051D);
			2: t = AW'(32'h09FB385B);  3: t = AW'(32'h051111D4);
			4: t = AW'(32'h028B0D43);  5: t = AW'(32'h0145D7E1);
			6: t = AW'(32'h00A2F61E);  7: t = AW'(32'h00517C55);
			8: t = AW'(32'h0028BE53);  9: t = AW'(32'h00145F2E);
			10: t = AW'(32'h000A2F98); 11: t = AW'(32'h000517CC);
			12: t = AW'(32'h00028BE6); 13: t = AW'(32'h000145F3);
			14: t = AW'(32'h0000A2F9); 15: t = AW'(32'h0000517C);
			16: t = AW'(32'h000028BE); 17: t = AW'(32'h0000145F);
			18: t = AW'(32'h00000A2F); 19: t = AW'(32'h00000517);
			20: t = AW'(32'h0000028B); 21: t = AW'(32'h00000145);
			22: t = AW'(32'h000000A2); 23: t = AW'(32'h00000051);
			24: t = AW'(32'h00000028); 25: t = AW'(32'h00000014);
			26: t = AW'(32'h0000000A); 27: t = AW'(32'h00000005);
			28: t = AW'(32'h00000002); default: t = AW'(32'h00000001);
		endcase
		return t;
	endfunction

	// one vectoring micro-rotation
	function automatic vec_t rot_step(input vec_t v, input int i);
		vec_t o;
		dval_t dx, dy;
		dx = v.y >>> i;
		dy = v.x >>> i;
		o.zero = v.zero;
		if (!v.y[DW-1]) begin
			o.x = v.x + dx; o.y = v.y - dy; o.acc = v.acc + atan_entry(i);
		end else begin
			o.x = v.x - dx; o.y = v.y + dy; o.acc = v.acc - atan_entry(i);
		end
		return o;
	endfunction

	// quadrant pre-rotation; both operands zero marks an angle of zero
	function automatic vec_t pre_rot(input dval_t y, input dval_t x);
		vec_t o;
		o.x = x; o.y = y; o.acc = '0;
		o.zero = (x == '0) && (y == '0);
		if (x[DW-1]) begin
			if (!y[DW-1]) begin
				o.x = y; o.y = -x; o.acc = AW'(ONE_Q30);
			end else begin
				o.x = -y; o.y = x; o.acc = -AW'(ONE_Q30);
			end
		end
		return o;
	endfunction

	function automatic logic [15:0] ang_out(input vec_t v);
		ang_t t;
		t = v.acc + AW'(32'h8000);
		return v.zero ? 16'd0 : t[31:16];
	endfunction
endpackage

@@ src/q2e_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit step of the pipelined square root for the pitch cosine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module q2e_sqrt_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] rem_i,
	input  logic [30:0] root_i,
	input  logic [61:0] rad_i,
	output logic [61:0] rem_o,
	output logic [30:0] root_o,
	output logic [61:0] rad_o
);
	import q2e_pkg::*;
	logic [61:0] r2, trial;
	logic [30:0] rn;
	always_comb begin
		r2    = {rem_i[59:0], rad_i[61:60]};
		trial = {29'd0, root_i, 2'b01};
		rn    = {root_i[29:0], 1'b0};
		if (r2 >= trial) begin
			rn = {root_i[29:0], 1'b1};
			r2 = r2 - trial;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= r2;
			root_o <= rn;
			rad_o  <= {rad_i[59:0], 2'b00};
		end
	end
endmodule

@@ src/q2e_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One CORDIC iteration for the three angle lanes, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module q2e_cordic_cell (
	input  logic                 clk,
	input  logic                 en,
	input  int                   idx,
	input  q2e_pkg::lane_t       lane_i,
	output q2e_pkg::lane_t       lane_o
);
	import q2e_pkg::*;
	always_ff @(posedge clk) begin
		if (en) begin
			lane_o.p    <= rot_step(lane_i.p, idx);
			lane_o.yw   <= rot_step(lane_i.yw, idx);
			lane_o.r    <= rot_step(lane_i.r, idx);
			lane_o.lock <= lane_i.lock;
		end
	end
endmodule

@@ src/quaternion_to_euler_unit.sv @@
// Pipeline: front stages s1 to s4, the sqrt digit row, the CORDIC row and the output register.
// Throughput: one quaternion word per cycle; a stalled output freezes the whole pipe.
// Rate set by the row of sqrt digit cells and CORDIC cells, each a registered stage.
// Reset clears valid bits and loads thresh_q with about 0.99999.
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Quaternion to yaw-pitch-roll Euler angles with pipelined CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module quaternion_to_euler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic signed [15:0] roll_angle,
	output logic               gimbal_locked
);
	import q2e_pkg::*;

	localparam int NPRE = 4;
	localparam int NSQ  = SQW;
	localparam int NV   = NPRE + NSQ + STEPS + 1;

	logic [30:0] thresh_q;
	logic [NV-1:0] vld_q;
	logic en;

	assign en        = !vld_q[NV-1] || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			vld_q    <= '0;
		end else begin
			if (cfg_valid) thresh_q <= cfg_data;
			if (en) vld_q <= {vld_q[NV-2:0], in_valid};
		end
	end

	// s1: products
	logic signed [31:0] xw_s1, yz_s1, xz_s1, yw_s1, xy_s1, zw_s1, ww_s1, xx_s1, yy_s1, zz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			xw_s1 <= quat_x * quat_w; yz_s1 <= quat_y * quat_z;
			xz_s1 <= quat_x * quat_z; yw_s1 <= quat_y * quat_w;
			xy_s1 <= quat_x * quat_y; zw_s1 <= quat_z * quat_w;
			ww_s1 <= quat_w * quat_w; xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y; zz_s1 <= quat_z * quat_z;
		end
	end

	// s2: sums, saturation, lock decision, operand select
	dval_t s_raw, s_sat, ya, yb, yla, ylb, ra, rb;
	logic [30:0] mag;
	logic lock;
	always_comb begin
		s_raw = (DW'(xw_s1) - DW'(yz_s1)) <<< 1;
		s_sat = s_raw;
		if (s_raw > ONE_Q30) s_sat = ONE_Q30;
		if (s_raw < -ONE_Q30) s_sat = -ONE_Q30;
		mag   = s_sat[DW-1] ? 31'(-s_sat) : 31'(s_sat);
		lock  = mag >= thresh_q;
		ya  = (DW'(xz_s1) + DW'(yw_s1)) <<< 1;
		yb  = ((DW'(ww_s1) + DW'(zz_s1)) <<< 1) - ONE_Q30;
		yla = (DW'(yw_s1) - DW'(xz_s1)) <<< 1;
		ylb = ((DW'(ww_s1) + DW'(xx_s1)) <<< 1) - ONE_Q30;
		ra  = (DW'(xy_s1) + DW'(zw_s1)) <<< 1;
		rb  = ((DW'(ww_s1) + DW'(yy_s1)) <<< 1) - ONE_Q30;
	end

	dval_t s_s2, yy_s2, yx_s2, ry_s2, rx_s2;
	logic [30:0] mag_s2;
	logic lock_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2    <= s_sat;
			mag_s2  <= mag;
			lock_s2 <= lock;
			yy_s2   <= lock ? yla : ya;
			yx_s2   <= lock ? ylb : yb;
			ry_s2   <= ra;
			rx_s2   <= rb;
		end
	end

	// s3: magnitude squared
	logic [61:0] msq_s3;
	dval_t s_s3, yy_s3, yx_s3, ry_s3, rx_s3;
	logic lock_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			msq_s3  <= 62'(mag_s2) * 62'(mag_s2);
			s_s3 <= s_s2; yy_s3 <= yy_s2; yx_s3 <= yx_s2;
			ry_s3 <= ry_s2; rx_s3 <= rx_s2; lock_s3 <= lock_s2;
		end
	end

	// s4: radicand 2^60 - m^2 (fits 61 bits)
	logic [61:0] rad_s4;
	dval_t s_s4, yy_s4, yx_s4, ry_s4, rx_s4;
	logic lock_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4  <= (62'd1 << 60) - msq_s3;
			s_s4 <= s_s3; yy_s4 <= yy_s3; yx_s4 <= yx_s3;
			ry_s4 <= ry_s3; rx_s4 <= rx_s3; lock_s4 <= lock_s3;
		end
	end

	// square root digit row, with delay line for the other operands
	logic [61:0] rem_d [NSQ+1];
	logic [30:0] root_d [NSQ+1];
	logic [61:0] rad_d [NSQ+1];
	dval_t sd [NSQ+1], yyd [NSQ+1], yxd [NSQ+1], ryd [NSQ+1], rxd [NSQ+1];
	logic lkd [NSQ+1];
	assign rem_d[0]  = '0;
	assign root_d[0] = '0;
	assign rad_d[0]  = rad_s4;
	assign sd[0] = s_s4; assign yyd[0] = yy_s4; assign yxd[0] = yx_s4;
	assign ryd[0] = ry_s4; assign rxd[0] = rx_s4; assign lkd[0] = lock_s4;

	for (genvar g = 0; g < NSQ; g++) begin : g_sq
		q2e_sqrt_cell u_cell (
			.clk(clk), .en(en),
			.rem_i(rem_d[g]), .root_i(root_d[g]), .rad_i(rad_d[g]),
			.rem_o(rem_d[g+1]), .root_o(root_d[g+1]), .rad_o(rad_d[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sd[g+1] <= sd[g]; yyd[g+1] <= yyd[g]; yxd[g+1] <= yxd[g];
				ryd[g+1] <= ryd[g]; rxd[g+1] <= rxd[g]; lkd[g+1] <= lkd[g];
			end
		end
	end

	// CORDIC row
	lane_t ln [STEPS+1];
	always_comb begin
		ln[0].p    = pre_rot(sd[NSQ], DW'({1'b0, root_d[NSQ]}));
		ln[0].yw   = pre_rot(yyd[NSQ], yxd[NSQ]);
		ln[0].r    = pre_rot(ryd[NSQ], rxd[NSQ]);
		ln[0].lock = lkd[NSQ];
	end
	for (genvar g = 0; g < STEPS; g++) begin : g_cd
		q2e_cordic_cell u_cell (
			.clk(clk), .en(en), .idx(g), .lane_i(ln[g]), .lane_o(ln[g+1])
		);
	end

	// output register; a lane whose operands were both zero gives angle 0
	logic [15:0] p_q, y_q, r_q;
	logic lk_q;
	always_ff @(posedge clk) begin
		if (en) begin
			p_q  <= ang_out(ln[STEPS].p);
			y_q  <= ang_out(ln[STEPS].yw);
			r_q  <= ln[STEPS].lock ? 16'd0 : ang_out(ln[STEPS].r);
			lk_q <= ln[STEPS].lock;
		end
	end
	assign pitch_angle   = p_q;
	assign yaw_angle     = y_q;
	assign roll_angle    = r_q;
	assign gimbal_locked = lk_q;
endmodule

@@ src/q2e_checker.sv @@
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks on the quaternion unit handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_to_euler_unit_assert.svh"
module q2e_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] roll_angle,
	input logic               gimbal_locked
);
	`Q2E_ASSERT(a_lock_roll, !(out_valid && gimbal_locked) || roll_angle == 16'sd0, "roll not zero in lock")
	`Q2E_ASSERT(a_ready, !(out_valid && !out_ready) || !in_ready, "accepts while output stalled")
	`Q2E_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(roll_angle), "result dropped")
endmodule

bind quaternion_to_euler_unit q2e_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .roll_angle(roll_angle), .gimbal_locked(gimbal_locked)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_to_euler_unit: directed corner cases and
// random quaternions (unit, near gimbal lock, raw) go through the block under
// several lock thresholds and idle patterns. An in-bench fixed-point model
// predicts each angle word and a scoreboard checks the outputs in order.
// ----------------------------------------------------------------------------
module tb;
	import q2e_pkg::*;

	localparam int NSTEPS   = 16;
	localparam int DRAIN    = 80;
	localparam int WD_LIMIT = 4000;
	localparam longint Q30  = 64'sd1073741824;

	typedef struct {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
		logic               locked;
	} angles_t;

	class euler_scoreboard;
		angles_t     pending[$];
		logic [30:0] thresh;
		int          errors;

		function new();
			thresh = THRESH_RST;
			errors = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function logic [15:0] vec_angle(longint y, longint x);
			longint atab[30] = '{
				'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
				'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
				'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
				'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
				'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
				'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
			longint acc, t, dx, dy;
			acc = 0;
			if (x == 0 && y == 0) return 16'd0;
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; acc = Q30;
				end else begin
					x = -y; y = t; acc = -Q30;
				end
			end
			for (int i = 0; i < NSTEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; acc += atab[i];
				end else begin
					x -= dx; y += dy; acc -= atab[i];
				end
			end
			t = (acc + 32768) >>> 16;
			return t[15:0];
		endfunction

		function void note(logic signed [15:0] qw, qx, qy, qz);
			longint w, x, y, z, s;
			longint unsigned mag, c;
			angles_t e;
			w = qw; x = qx; y = qy; z = qz;
			s = 2 * (x * w - y * z);
			if (s > Q30) s = Q30;
			if (s < -Q30) s = -Q30;
			mag = (s < 0) ? -s : s;
			e.locked = mag >= longint'(thresh);
			c = int_sqrt((64'd1 << 60) - mag * mag);
			e.pitch = vec_angle(s, longint'(c));
			if (!e.locked) begin
				e.yaw  = vec_angle(2*x*z + 2*y*w, 2*w*w + 2*z*z - Q30);
				e.roll = vec_angle(2*x*y + 2*z*w, 2*w*w + 2*y*y - Q30);
			end else begin
				e.yaw  = vec_angle(2*y*w - 2*x*z, 2*w*w + 2*x*x - Q30);
				e.roll = 0;
			end
			pending.push_back(e);
		endfunction

		function void check(logic signed [15:0] p, yw, r, logic l);
			angles_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (p !== e.pitch) begin
				$error("pitch_angle exp %0d got %0d", e.pitch, p); errors++;
			end
			if (yw !== e.yaw) begin
				$error("yaw_angle exp %0d got %0d", e.yaw, yw); errors++;
			end
			if (r !== e.roll) begin
				$error("roll_angle exp %0d got %0d", e.roll, r); errors++;
			end
			if (l !== e.locked) begin
				$error("gimbal_locked exp %0d got %0d", e.locked, l); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [30:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
	logic out_valid, out_ready = 0;
	logic signed [15:0] pitch_angle, yaw_angle, roll_angle;
	logic gimbal_locked;

	euler_scoreboard sb = new();
	int send_gap_pct = 0, stall_pct = 0, quiet = 0;

	quaternion_to_euler_unit dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check(pitch_angle, yaw_angle, roll_angle, gimbal_locked);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WD_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_quat(logic signed [15:0] w, x, y, z);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		do @(posedge clk); while (!in_ready);
		sb.note(w, x, y, z);
	endtask

	task automatic write_thresh(logic [30:0] v);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.thresh = v;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom);
	endfunction

	task automatic send_random(int n);
		real a, b, c, d, k;
		int sel, j;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				send_quat(rnd16(), rnd16(), rnd16(), rnd16());
			end else if (sel < 55) begin
				j = 23170 + int'($urandom_range(400)) - 200;
				a = j;
				b = ($urandom_range(1)) ? j : -j;
				c = int'($urandom_range(300)) - 150;
				d = int'($urandom_range(300)) - 150;
				if ($urandom_range(1)) a = -a;
				send_quat(16'(int'(a)), 16'(int'(b)), 16'(int'(c)), 16'(int'(d)));
			end else begin
				a = $signed(rnd16()); b = $signed(rnd16());
				c = $signed(rnd16()); d = $signed(rnd16());
				k = $sqrt(a*a + b*b + c*c + d*d);
				if (k < 1.0) k = 1.0;
				k = 32767.0 / k;
				send_quat(16'(int'(a*k)), 16'(int'(b*k)), 16'(int'(c*k)), 16'(int'(d*k)));
			end
		end
	endtask

	initial begin
		logic [30:0] th[5] = '{31'd0, 31'd1073741824, 31'h7FFFFFFF,
			31'd1073000000, THRESH_RST};
		int gap[5] = '{65, 0, 7, 0, 65};
		int stl[5] = '{0, 65, 7, 0, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_quat(32767, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(23170, 23170, 0, 0);
		send_quat(23170, -23170, 0, 0);
		send_quat(-32768, -32768, 0, 0);
		send_quat(-32768, 32767, 0, 0);
		send_quat(0, 0, 23170, 23170);
		send_quat(16384, 0, 0, 16384);
		send_quat(0, 0, 0, 32767);
		send_quat(0, 0, 32767, 0);
		send_quat(0, 32767, 0, 0);
		send_quat(-1, 1, -1, 1);
		send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_random(150);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_thresh(th[p]);
			send_gap_pct = gap[p];
			stall_pct = stl[p];
			send_quat(23170, 23170, 0, 0);
			send_quat(-32768, -32768, 0, 0);
			send_random(130);
			drain();
		end

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

@@ quaternion_to_euler_unit.f @@
+incdir+src
src/q2e_pkg.sv
src/q2e_sqrt_cell.sv
src/q2e_cordic_cell.sv
src/quaternion_to_euler_unit.sv
src/q2e_checker.sv
tb/tb.sv
